// ----- src/mmt_pkg.sv -----
// Shared types and token kind codes of the maximal munch tokenizer.
package mmt_pkg;

    typedef logic [4:0] t_cls;

    // Token kinds as they leave the block.
    localparam t_cls K_LPAREN   = 5'd0;
    localparam t_cls K_RPAREN   = 5'd1;
    localparam t_cls K_LBRACKET = 5'd2;
    localparam t_cls K_RBRACKET = 5'd3;
    localparam t_cls K_LBRACE   = 5'd4;
    localparam t_cls K_RBRACE   = 5'd5;
    localparam t_cls K_COMMA    = 5'd6;
    localparam t_cls K_COLON    = 5'd7;
    localparam t_cls K_MUL      = 5'd8;
    localparam t_cls K_DIV      = 5'd9;
    localparam t_cls K_ADD      = 5'd10;
    localparam t_cls K_MINUS    = 5'd11;
    localparam t_cls K_EQUAL    = 5'd12;
    localparam t_cls K_LESS     = 5'd13;
    localparam t_cls K_GREATER  = 5'd14;
    localparam t_cls K_NOT      = 5'd15;
    localparam t_cls K_RARROW   = 5'd16;
    localparam t_cls K_LARROW   = 5'd17;
    localparam t_cls K_NEQ      = 5'd18;
    localparam t_cls K_NUMBER   = 5'd19;
    localparam t_cls K_IDENT    = 5'd20;
    localparam t_cls K_STRING   = 5'd21;
    // Pending token states that are not kinds.
    localparam t_cls CLS_EMPTY  = 5'd22;
    localparam t_cls CLS_STUCK  = 5'd23;

    // Entries in the queue between classifier and lexer.
    localparam int QUEUE_DEPTH = 2;

    // One classified source byte.
    typedef struct packed {
        t_cls single_cls;   // kind that this byte starts, or CLS_STUCK
        logic is_space;
        logic is_newline;
        logic is_semi;
        logic is_quote;
        logic is_backslash;
        logic eoi;
    } t_byte_info;

endpackage

// ----- src/mmt_front.sv -----
// Byte classifier: takes input items and turns each byte into class flags.
module mmt_front
    import mmt_pkg::*;
(
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_input,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_byte_info o_push_info
);

    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_EQUAL  = 8'h3D;
    localparam logic [7:0] C_LESS   = 8'h3C;
    localparam logic [7:0] C_GREAT  = 8'h3E;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_LF     = 8'h0A;

    logic is_digit;
    logic is_alpha;
    t_cls single_cls;

    assign is_digit = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
    assign is_alpha = ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A)) ||
                      ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A));

    always_comb begin
        unique case (i_char_code)
            C_LPAREN: single_cls = K_LPAREN;
            C_RPAREN: single_cls = K_RPAREN;
            C_LBRACK: single_cls = K_LBRACKET;
            C_RBRACK: single_cls = K_RBRACKET;
            C_LBRACE: single_cls = K_LBRACE;
            C_RBRACE: single_cls = K_RBRACE;
            C_COMMA:  single_cls = K_COMMA;
            C_COLON:  single_cls = K_COLON;
            C_STAR:   single_cls = K_MUL;
            C_SLASH:  single_cls = K_DIV;
            C_PLUS:   single_cls = K_ADD;
            C_MINUS:  single_cls = K_MINUS;
            C_EQUAL:  single_cls = K_EQUAL;
            C_LESS:   single_cls = K_LESS;
            C_GREAT:  single_cls = K_GREATER;
            C_BANG:   single_cls = K_NOT;
            C_DOT:    single_cls = K_NUMBER;
            default: begin
                if (is_digit) begin
                    single_cls = K_NUMBER;
                end else if (is_alpha) begin
                    single_cls = K_IDENT;
                end else begin
                    single_cls = CLS_STUCK;
                end
            end
        endcase
    end

    always_comb begin
        o_push_info.single_cls   = single_cls;
        o_push_info.is_space     = (i_char_code == C_SPACE) ||
                                   ((i_char_code >= C_TAB) && (i_char_code <= C_CR));
        o_push_info.is_newline   = (i_char_code == C_LF);
        o_push_info.is_semi      = (i_char_code == C_SEMI);
        o_push_info.is_quote     = (i_char_code == C_QUOTE);
        o_push_info.is_backslash = (i_char_code == C_BSLASH);
        o_push_info.eoi          = i_end_of_input;
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

// ----- src/mmt_queue.sv -----
// Short queue of classified bytes between the classifier and the lexer.
module mmt_queue
    import mmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push_valid,
    output logic       o_push_ready,
    input  t_byte_info i_push_info,
    output logic       o_pop_valid,
    input  logic       i_pop_ready,
    output t_byte_info o_pop_info
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);

    t_byte_info    r_mem [QUEUE_DEPTH];
    logic [IW-1:0] r_wr;
    logic [IW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_info   = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_info;
        end
    end

endmodule

// ----- src/mmt_back.sv -----
// Lexer state machine: applies classified bytes and registers token descriptors.
module mmt_back
    import mmt_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POS_WIDTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_byte_info  i_pop_info,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_token_kind,
    output logic [7:0]  o_token_length,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam int PW = (POS_WIDTH < 16) ? POS_WIDTH : 16;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_COMMENT,
        MODE_STRING,
        MODE_ESCAPE
    } t_mode;

    t_mode         r_mode, n_mode;
    t_cls          r_pend, n_pend;
    logic [LW-1:0] r_len, n_len;
    logic [PW-1:0] r_start_line, n_start_line;
    logic [PW-1:0] r_start_col, n_start_col;
    logic [PW-1:0] r_cur_line, n_cur_line;
    logic [PW-1:0] r_cur_col, n_cur_col;
    logic          r_out_valid;
    logic [4:0]    r_kind;
    logic [7:0]    r_length;
    logic [PW-1:0] r_line;
    logic [PW-1:0] r_col;

    logic          take;
    logic          emit;
    t_cls          emit_kind;
    t_cls          ext_cls;
    logic [LW-1:0] len_inc;
    logic [LW+7:0] len_wide;
    logic [7:0]    len_out;
    logic [PW-1:0] adv_line;
    logic [PW-1:0] adv_col;
    logic          pend_valid;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign take        = i_pop_valid && o_pop_ready;
    assign pend_valid  = (r_pend < CLS_EMPTY);
    assign len_inc     = (r_len < LEN_MAX) ? r_len + 1'b1 : r_len;
    assign len_wide    = (LW + 8)'(r_len);
    assign len_out     = (len_wide > (LW + 8)'(255)) ? 8'hFF : len_wide[7:0];

    // Position after this byte.
    always_comb begin
        if (i_pop_info.is_newline) begin
            adv_line = (r_cur_line < POS_MAX) ? r_cur_line + 1'b1 : r_cur_line;
            adv_col  = POS_ONE;
        end else begin
            adv_line = r_cur_line;
            adv_col  = (r_cur_col < POS_MAX) ? r_cur_col + 1'b1 : r_cur_col;
        end
    end

    // Kind of the pending token with this byte appended, or stuck.
    always_comb begin
        case (r_pend)
            K_MINUS:  ext_cls = (i_pop_info.single_cls == K_GREATER) ? K_RARROW : CLS_STUCK;
            K_LESS:   ext_cls = (i_pop_info.single_cls == K_MINUS) ? K_LARROW : CLS_STUCK;
            K_EQUAL:  ext_cls = (r_len == LW'(1) && i_pop_info.single_cls == K_EQUAL) ?
                                K_EQUAL : CLS_STUCK;
            K_NOT:    ext_cls = (i_pop_info.single_cls == K_EQUAL) ? K_NEQ : CLS_STUCK;
            K_NUMBER: ext_cls = (i_pop_info.single_cls == K_NUMBER) ? K_NUMBER : CLS_STUCK;
            K_IDENT:  ext_cls = (i_pop_info.single_cls == K_IDENT) ? K_IDENT : CLS_STUCK;
            default:  ext_cls = CLS_STUCK;
        endcase
    end

    always_comb begin
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_len        = r_len;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_cur_line   = adv_line;
        n_cur_col    = adv_col;
        emit         = 1'b0;
        emit_kind    = r_pend;
        if (i_pop_info.eoi) begin
            // End of source: flush a valid token, then start over.
            emit         = (r_mode == MODE_NORMAL) && pend_valid;
            n_mode       = MODE_NORMAL;
            n_pend       = CLS_EMPTY;
            n_len        = '0;
            n_start_line = POS_ONE;
            n_start_col  = POS_ONE;
            n_cur_line   = POS_ONE;
            n_cur_col    = POS_ONE;
        end else begin
            unique case (r_mode)
                MODE_COMMENT: begin
                    if (i_pop_info.is_newline) begin
                        n_mode = MODE_NORMAL;
                    end
                end
                MODE_STRING: begin
                    if (i_pop_info.is_quote) begin
                        emit      = 1'b1;
                        emit_kind = K_STRING;
                        n_mode    = MODE_NORMAL;
                        n_pend    = CLS_EMPTY;
                        n_len     = '0;
                    end else begin
                        n_len = len_inc;
                        if (i_pop_info.is_backslash) begin
                            n_mode = MODE_ESCAPE;
                        end
                    end
                end
                MODE_ESCAPE: begin
                    n_len  = len_inc;
                    n_mode = MODE_STRING;
                end
                default: begin
                    if (i_pop_info.is_semi || i_pop_info.is_quote) begin
                        emit   = pend_valid;
                        n_pend = CLS_EMPTY;
                        n_len  = '0;
                        if (i_pop_info.is_quote) begin
                            n_mode       = MODE_STRING;
                            n_start_line = adv_line;
                            n_start_col  = adv_col;
                        end else begin
                            n_mode = MODE_COMMENT;
                        end
                    end else if (r_pend == CLS_STUCK) begin
                        if (!i_pop_info.is_space) begin
                            n_len = len_inc;
                        end
                    end else if (r_pend != CLS_EMPTY && ext_cls != CLS_STUCK) begin
                        n_pend = ext_cls;
                        n_len  = len_inc;
                    end else begin
                        // Either nothing pending, or the byte ends the token.
                        emit   = pend_valid;
                        n_pend = CLS_EMPTY;
                        n_len  = '0;
                        if (!i_pop_info.is_space) begin
                            n_pend       = i_pop_info.single_cls;
                            n_len        = LW'(1);
                            n_start_line = r_cur_line;
                            n_start_col  = r_cur_col;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_pend       <= CLS_EMPTY;
            r_len        <= '0;
            r_start_line <= POS_ONE;
            r_start_col  <= POS_ONE;
            r_cur_line   <= POS_ONE;
            r_cur_col    <= POS_ONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (take) begin
                r_mode       <= n_mode;
                r_pend       <= n_pend;
                r_len        <= n_len;
                r_start_line <= n_start_line;
                r_start_col  <= n_start_col;
                r_cur_line   <= n_cur_line;
                r_cur_col    <= n_cur_col;
            end
            if (take && emit) begin
                r_out_valid <= 1'b1;
                r_kind      <= emit_kind;
                r_length    <= len_out;
                r_line      <= r_start_line;
                r_col       <= r_start_col;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_token_kind   = r_kind;
    assign o_token_length = r_length;
    assign o_token_line   = 16'(r_line);
    assign o_token_column = 16'(r_col);

endmodule

// ----- src/maximal_munch_tokenizer_core.sv -----
// Top level of the maximal munch tokenizer: classifier, queue and lexer.
//
// The input channel (i_in_valid / o_in_ready) carries one source byte per item
// together with an end-of-input flag. The output channel (o_out_valid /
// i_out_ready) carries token descriptors: kind, length, start line and start
// column. Each item is accepted when its valid and ready are both high.
//
// A token is reported by the byte that ends it: the byte is written into
// the two-entry queue, the lexer reads it from there, and the lexer's
// output register then presents the descriptor. The block takes one byte
// per cycle while the receiver keeps up.
//
// When the receiver stalls, the output register holds its descriptor and the
// lexer stops; the queue absorbs up to two more bytes before o_in_ready falls.
// An item with the end-of-input flag set flushes the last valid token and puts
// the lexer back to its start state, so the next byte begins a new source.
// Reset (synchronous, active low) empties the queue and the output register and
// sets line and column to one. No clearing pass is needed.
module maximal_munch_tokenizer_core
    import mmt_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int POS_WIDTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_token_kind,
    output logic [7:0]  o_token_length,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column
);

    logic       push_valid;
    logic       push_ready;
    t_byte_info push_info;
    logic       pop_valid;
    logic       pop_ready;
    t_byte_info pop_info;

    // Classification of each byte happens before it enters the queue.
    mmt_front u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_info    (push_info)
    );

    // The queue lets the input side keep taking bytes while the lexer waits.
    mmt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_info  (push_info),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_info   (pop_info)
    );

    // The lexer holds the pending token and the position counters.
    mmt_back #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POS_WIDTH     (POS_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_info     (pop_info),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the maximal munch tokenizer core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mmt_pkg::*;

    // Block configuration under test; the predictor uses the same bounds.
    localparam int MAX_LEN      = 255;
    localparam int POS_W        = 16;
    localparam int POS_LIMIT    = (POS_W >= 16) ? 65535 : (1 << POS_W) - 1;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 210;
    localparam int HOLD_CYCLES  = 300;
    // Tokens leave after the byte that ends them has passed the queue and
    // the lexer; the drain outlasts the longest random receiver stall, so a
    // stray token still in flight is caught.
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 100;

    // Byte codes with a special meaning to the lexer.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Lexer modes: plain source, inside a comment, inside a string, and the
    // byte right after a backslash in a string.
    typedef enum logic [1:0] {
        LEX_NORMAL,
        LEX_COMMENT,
        LEX_STRING,
        LEX_ESCAPE
    } lex_mode_e;

    // One token descriptor as it should leave the block.
    typedef struct {
        t_cls        kind;
        logic [7:0]  length;
        logic [15:0] line;
        logic [15:0] column;
    } token_desc_t;

    // Tracks the lexer state for every accepted byte and keeps the tokens that
    // those bytes must produce, oldest first.
    class token_predictor;
        lex_mode_e   mode;
        t_cls        pend_kind;
        int          pend_len;
        int          start_line;
        int          start_col;
        int          cur_line;
        int          cur_col;
        token_desc_t expected_tokens[$];
        int          failures;
        int          reports;

        function new();
            restart();
            failures = 0;
            reports  = 0;
        endfunction

        // State after reset and after every end-of-input item.
        function void restart();
            mode       = LEX_NORMAL;
            pend_kind  = CLS_EMPTY;
            pend_len   = 0;
            start_line = 1;
            start_col  = 1;
            cur_line   = 1;
            cur_col    = 1;
        endfunction

        function int waiting();
            return expected_tokens.size();
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit is_num_char(logic [7:0] c);
            return (c >= "0" && c <= "9") || c == CH_DOT;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        // Kind of the token that a byte opens, or stuck if it opens none.
        function t_cls first_kind(logic [7:0] c);
            case (c)
                "(": return K_LPAREN;
                ")": return K_RPAREN;
                "[": return K_LBRACKET;
                "]": return K_RBRACKET;
                "{": return K_LBRACE;
                "}": return K_RBRACE;
                ",": return K_COMMA;
                ":": return K_COLON;
                "*": return K_MUL;
                "/": return K_DIV;
                "+": return K_ADD;
                "-": return K_MINUS;
                "=": return K_EQUAL;
                "<": return K_LESS;
                ">": return K_GREATER;
                "!": return K_NOT;
                default: ;
            endcase
            if (is_num_char(c)) return K_NUMBER;
            if (is_letter(c)) return K_IDENT;
            return CLS_STUCK;
        endfunction

        // Kind after appending a byte to a valid pending token; stuck means
        // the pending token is complete.
        function t_cls next_kind(t_cls kind, int len, logic [7:0] c);
            case (kind)
                K_MINUS:  return (c == ">") ? K_RARROW : CLS_STUCK;
                K_LESS:   return (c == "-") ? K_LARROW : CLS_STUCK;
                K_EQUAL:  return (len == 1 && c == "=") ? K_EQUAL : CLS_STUCK;
                K_NOT:    return (c == "=") ? K_NEQ : CLS_STUCK;
                K_NUMBER: return is_num_char(c) ? K_NUMBER : CLS_STUCK;
                K_IDENT:  return is_letter(c) ? K_IDENT : CLS_STUCK;
                default:  return CLS_STUCK;
            endcase
        endfunction

        function int grow(int len);
            return (len < MAX_LEN) ? len + 1 : MAX_LEN;
        endfunction

        function void step_pos(logic [7:0] c);
            if (c == CH_LF) begin
                if (cur_line < POS_LIMIT) cur_line++;
                cur_col = 1;
            end else if (cur_col < POS_LIMIT) begin
                cur_col++;
            end
        endfunction

        function void push(t_cls kind);
            token_desc_t t;
            t.kind   = kind;
            t.length = (pend_len > 255) ? 8'd255 : pend_len[7:0];
            t.line   = start_line[15:0];
            t.column = start_col[15:0];
            expected_tokens.push_back(t);
        endfunction

        function void open(t_cls kind);
            pend_kind  = kind;
            pend_len   = 1;
            start_line = cur_line;
            start_col  = cur_col;
        endfunction

        // Called once per accepted input item.
        function void note_byte(logic [7:0] c, logic eoi);
            t_cls nk;
            if (eoi) begin
                // Only a valid token in plain source survives the flush.
                if (mode == LEX_NORMAL && pend_kind < CLS_EMPTY) push(pend_kind);
                restart();
                return;
            end
            case (mode)
                LEX_COMMENT: begin
                    if (c == CH_LF) mode = LEX_NORMAL;
                    step_pos(c);
                end
                LEX_STRING: begin
                    if (c == CH_QUOTE) begin
                        push(K_STRING);
                        mode      = LEX_NORMAL;
                        pend_kind = CLS_EMPTY;
                        pend_len  = 0;
                    end else begin
                        pend_len = grow(pend_len);
                        if (c == CH_BSLASH) mode = LEX_ESCAPE;
                    end
                    step_pos(c);
                end
                LEX_ESCAPE: begin
                    pend_len = grow(pend_len);
                    mode     = LEX_STRING;
                    step_pos(c);
                end
                default: begin
                    if (c == CH_SEMI || c == CH_QUOTE) begin
                        // Close whatever is pending; a stuck token just drops.
                        if (pend_kind < CLS_EMPTY) push(pend_kind);
                        pend_kind = CLS_EMPTY;
                        pend_len  = 0;
                        step_pos(c);
                        if (c == CH_QUOTE) begin
                            // A string starts at the byte after its quote.
                            mode       = LEX_STRING;
                            start_line = cur_line;
                            start_col  = cur_col;
                        end else begin
                            mode = LEX_COMMENT;
                        end
                    end else if (pend_kind == CLS_STUCK) begin
                        if (!is_blank(c)) pend_len = grow(pend_len);
                        step_pos(c);
                    end else if (pend_kind == CLS_EMPTY) begin
                        if (!is_blank(c)) open(first_kind(c));
                        step_pos(c);
                    end else begin
                        nk = next_kind(pend_kind, pend_len, c);
                        if (nk != CLS_STUCK) begin
                            pend_kind = nk;
                            pend_len  = grow(pend_len);
                        end else begin
                            push(pend_kind);
                            pend_kind = CLS_EMPTY;
                            pend_len  = 0;
                            if (!is_blank(c)) open(first_kind(c));
                        end
                        step_pos(c);
                    end
                end
            endcase
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: token %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
                end
            end
        endfunction

        // Called once per token item taken from the block.
        function void check_token(logic [4:0] kind, logic [7:0] length,
                                  logic [15:0] line, logic [15:0] column);
            token_desc_t want;
            if (expected_tokens.size() == 0) begin
                failures++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t: unexpected token, expected none, actual kind %0d",
                             $time, kind, " length %0d line %0d column %0d",
                             length, line, column);
                end
                return;
            end
            want = expected_tokens.pop_front();
            compare("kind", 16'(want.kind), 16'(kind));
            compare("length", 16'(want.length), 16'(length));
            compare("line", want.line, line);
            compare("column", want.column, column);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_code;
    logic        i_end_of_input;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_token_kind;
    logic [7:0]  o_token_length;
    logic [15:0] o_token_line;
    logic [15:0] o_token_column;

    token_predictor token_pred;
    int sent_items  = 0;
    int cycle_count = 0;
    int send_calm   = 0;
    int recv_calm   = 0;
    int recv_stall  = 0;
    bit hold_asked  = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    maximal_munch_tokenizer_core #(
        .MAX_TOKEN_LEN (MAX_LEN),
        .POS_WIDTH     (POS_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column)
    );

    // Random idle length: mostly none or short, now and then long, and every
    // so often a calm stretch with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offers one item and waits until the block takes it. Valid stays high
    // across back-to-back items; it only drops during an idle gap.
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        int gap;
        gap = pick_gap(send_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_char_code    <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        token_pred.note_byte(c, eoi);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // End of input; the byte that rides along is ignored by the block.
    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Any byte except a quote, which would end a string early, and a backslash.
    function automatic logic [7:0] string_filler();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE || b == CH_BSLASH) b = "q";
        return b;
    endfunction

    // One well-formed lexeme with random content, or now and then noise,
    // an end of input, or a string cut off by the end of input.
    task automatic send_lexeme();
        string ops     = "()[]{},:*/+-=<>!";
        string nums    = "0123456789.";
        string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        string blanks  = " \011\012\013\014\015";
        string pairs[4] = '{"->", "<-", "==", "!="};
        logic [7:0] b;
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            send_byte(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
        end else if (pick < 28) begin
            send_text(pairs[$urandom_range(0, 3)]);
        end else if (pick < 43) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(nums[$urandom_range(0, nums.len() - 1)], 1'b0);
        end else if (pick < 63) begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(letters[$urandom_range(0, letters.len() - 1)], 1'b0);
        end else if (pick < 74) begin
            // Quoted string, sometimes empty, with escapes that may hide a quote.
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 10);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_byte(CH_BSLASH, 1'b0);
                    send_byte($urandom_range(0, 1) ? CH_QUOTE : string_filler(), 1'b0);
                end else begin
                    send_byte(string_filler(), 1'b0);
                end
            end
            send_byte(CH_QUOTE, 1'b0);
        end else if (pick < 81) begin
            // Comment; quotes and semicolons inside must be ignored.
            send_byte(CH_SEMI, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) begin
                b = ($urandom_range(0, 3) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
                if (b == CH_LF) b = CH_SEMI;
                send_byte(b, 1'b0);
            end
            send_byte(CH_LF, 1'b0);
        end else if (pick < 91) begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(blanks[$urandom_range(0, blanks.len() - 1)], 1'b0);
        end else if (pick < 94) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 98) begin
            send_end();
        end else begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 4);
            repeat (n) send_byte(string_filler(), 1'b0);
            send_end();
        end
        // Half the lexemes run straight into the next one, which is where
        // longest match decides where a token ends.
        if ($urandom_range(0, 1) == 0) send_byte(CH_SPACE, 1'b0);
    endtask

    // Every token item that the block hands over is checked at the edge at
    // which it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            token_pred.check_token(o_token_kind, o_token_length, o_token_line,
                                   o_token_column);
        end
    end

    // Watchdog: a hung handshake or a lost token ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls after every ready cycle, plus one long hold-off
    // on request so the block fills up and pushes back on the sender.
    initial begin : receiver
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_asked) begin
                hold_asked = 1'b0;
                recv_stall = HOLD_CYCLES;
            end
            if (recv_stall > 0) begin
                i_out_ready <= 1'b0;
                recv_stall--;
            end else begin
                i_out_ready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    initial begin : stimulus
        int long_len;
        int random_target;
        bit hold_done;
        hold_done      = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_char_code    = 8'h00;
        i_end_of_input = 1'b0;
        i_out_ready    = 1'b0;
        token_pred     = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Bracket, identifier cut by a digit, number cut by a
        // minus, right arrow, empty string, not-equal.
        send_text("[a1->\"\"!=");
        // A comment that swallows the top byte value, closed by a newline.
        send_byte(CH_SEMI, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_LF, 1'b0);
        // Left arrow, then double equal, then a lone equal.
        send_text("<-===");
        // A zero byte makes the text stuck; the end of input drops it.
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);
        // Unterminated string ending in a backslash emits nothing.
        send_text("\"a\\");
        send_end();
        // A lone identifier only leaves on the end-of-input flush.
        send_text("x");
        send_end();

        // Random part. It opens with an identifier long enough to saturate
        // the length field.
        long_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 7);
        repeat (long_len) begin
            send_byte($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                           : 8'($urandom_range("A", "Z")), 1'b0);
        end
        send_byte(CH_SPACE, 1'b0);
        random_target = sent_items + RANDOM_ITEMS;
        while (sent_items < random_target) begin
            if (!hold_done && sent_items > random_target - RANDOM_ITEMS + 150) begin
                hold_asked = 1'b1;
                hold_done  = 1'b1;
            end
            send_lexeme();
        end
        send_end();
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (token_pred.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (token_pred.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
